### rtl/core/mtcd_pkg.sv
// Shared types, constants and register indexes for the missing-tooth crank decoder.
// No dependencies; every module of the decoder imports this package.
package mtcd_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int PERIOD_W     = 16;
  localparam int SUM_W        = PERIOD_W + WIN_AW;
  localparam int TOOTH_W      = 6;
  localparam int SAMPLE_W     = 4;
  localparam int STATUS_W     = 2;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 16;
  localparam int OUT_DW       = 32;

  localparam logic [WIN_AW-1:0]   PTR_LAST    = WIN_AW'(WINDOW_DEPTH - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = '1;
  localparam logic [TOOTH_W-1:0]  TOOTH_FIRST = TOOTH_W'(1);

  localparam logic [STATUS_W-1:0] STATUS_INIT  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CRANK = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd2;

  localparam logic [CFG_AW-1:0] REG_MIN_PERIOD    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_PERIOD    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STABLE_LIMIT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_SAMPLES   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RUN_THRESHOLD = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TEETH_PER_REV = 3'd5;

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_GATHER = 2'd1,
    PH_HUNT   = 2'd2,
    PH_SYNC   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] min_period;
    logic [PERIOD_W-1:0] max_period;
    logic [PERIOD_W-1:0] stable_limit;
    logic [SAMPLE_W-1:0] min_samples;
    logic [PERIOD_W-1:0] run_threshold;
    logic [TOOTH_W-1:0]  teeth_per_rev;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [SAMPLE_W-1:0] sample_count;
    logic [TOOTH_W-1:0]  tooth_pos;
    logic [WIN_AW-1:0]   window_pointer;
    logic [SUM_W-1:0]    period_sum;
    logic                fault;
  } dec_state_t;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic                fault;
    logic [PERIOD_W-1:0] average_period;
    logic [TOOTH_W-1:0]  tooth_number;
    logic                tooth_tick;
    logic                sync_mark;
    logic [STATUS_W-1:0] engine_status;
  } result_t;

endpackage

### rtl/core/mtcd_step.sv
// Next-state and result logic for one tooth period of the crank decoder.
// Depends on mtcd_pkg; purely combinational, used by the top level.
module mtcd_step (
  input  mtcd_pkg::cfg_t                      cfg,
  input  mtcd_pkg::dec_state_t                st,
  input  logic [mtcd_pkg::PERIOD_W-1:0]       period,
  input  logic [mtcd_pkg::PERIOD_W-1:0]       old_entry,
  output mtcd_pkg::dec_state_t                st_next,
  output mtcd_pkg::win_ctl_t                  win,
  output mtcd_pkg::result_t                   res
);
  import mtcd_pkg::*;

  phase_t              ph;
  logic                glitch;
  logic                is_gap;
  logic [PERIOD_W-1:0] avg_cur;
  logic [SAMPLE_W-1:0] scount;

  assign glitch  = (period > cfg.max_period) || (period < cfg.min_period);
  assign avg_cur = st.period_sum[SUM_W-1:WIN_AW];
  assign is_gap  = {1'b0, period} > {avg_cur, 1'b0};

  always_comb begin
    st_next   = st;
    win       = '0;
    res       = '0;
    ph        = st.phase;
    scount    = st.sample_count;
    if (glitch) begin
      if (st.phase == PH_SYNC) begin
        st_next.fault = 1'b1;
      end
      ph = PH_INIT;
    end
    case (ph)
      PH_INIT: begin
        scount            = '0;
        st_next.tooth_pos = TOOTH_FIRST;
        win.clear         = 1'b1;
        st_next.phase     = PH_GATHER;
      end
      PH_GATHER: begin
        if (period < cfg.stable_limit) begin
          win.push = 1'b1;
          if (scount >= cfg.min_samples) begin
            scount        = '0;
            st_next.phase = PH_HUNT;
          end
        end else begin
          st_next.phase = PH_INIT;
        end
      end
      PH_HUNT: begin
        res.engine_status = STATUS_CRANK;
        if (is_gap) begin
          scount            = '0;
          st_next.tooth_pos = TOOTH_FIRST;
          res.sync_mark     = 1'b1;
          res.tooth_number  = TOOTH_FIRST;
          st_next.phase     = PH_SYNC;
        end else begin
          win.push = 1'b1;
        end
      end
      PH_SYNC: begin
        res.engine_status = (avg_cur > cfg.run_threshold) ? STATUS_CRANK : STATUS_RUN;
        if (st.tooth_pos >= cfg.teeth_per_rev) begin
          st_next.tooth_pos = TOOTH_FIRST;
          if (!is_gap) begin
            st_next.fault = 1'b1;
            st_next.phase = PH_INIT;
          end
        end else begin
          st_next.tooth_pos = st.tooth_pos + TOOTH_FIRST;
          win.push          = 1'b1;
        end
        res.tooth_tick   = 1'b1;
        res.tooth_number = st_next.tooth_pos;
      end
      default: begin
        st_next.phase = PH_INIT;
      end
    endcase
    st_next.sample_count = (scount < SAMPLE_MAX) ? scount + SAMPLE_W'(1) : scount;
    if (win.clear) begin
      st_next.period_sum     = '0;
      st_next.window_pointer = '0;
    end else if (win.push) begin
      st_next.period_sum = st.period_sum + SUM_W'(period) - SUM_W'(old_entry);
      st_next.window_pointer = (st.window_pointer == PTR_LAST) ? '0
                             : st.window_pointer + WIN_AW'(1);
    end
    res.average_period = st_next.period_sum[SUM_W-1:WIN_AW];
    res.fault          = st_next.fault;
  end

endmodule

### rtl/core/missing_tooth_crank_decoder.sv
// Top level of the missing-tooth crank decoder: streams, configuration registers,
// decoder state and the moving-average window. Depends on mtcd_pkg and mtcd_step.
module missing_tooth_crank_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mtcd_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [mtcd_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] tooth_period
  input  logic [mtcd_pkg::PERIOD_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] engine_status, [2] sync_mark, [3] tooth_tick, [9:4] tooth_number,
  // [25:10] average_period, [26] trigger_fault, [31:27] zero
  output logic [mtcd_pkg::OUT_DW-1:0]     m_tdata
);
  import mtcd_pkg::*;

  // The decoder takes one tooth period per clock cycle while the output is not
  // stalled and returns exactly one result per request. A request is captured in
  // an input register; once the result register is free, a single pass of logic
  // updates the phase, tooth counter, eight-entry window and running sum and loads
  // the result register. A stalled result holds the input register, so at most
  // two requests are in flight. Configuration is to be written through cfg_we,
  // cfg_addr and cfg_wdata only while the decoder is idle; nothing enforces it.

  cfg_t                cfg;
  dec_state_t          st;
  dec_state_t          st_next;
  win_ctl_t            win;
  result_t             res;
  result_t             out_res;
  logic [PERIOD_W-1:0] window [WINDOW_DEPTH];
  logic [PERIOD_W-1:0] in_period;
  logic                in_valid;
  logic                fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_period    <= 16'd166;
      cfg.max_period    <= 16'd65535;
      cfg.stable_limit  <= 16'd20000;
      cfg.min_samples   <= 4'd10;
      cfg.run_threshold <= 16'd2000;
      cfg.teeth_per_rev <= 6'd58;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_PERIOD:    cfg.min_period    <= cfg_wdata;
        REG_MAX_PERIOD:    cfg.max_period    <= cfg_wdata;
        REG_STABLE_LIMIT:  cfg.stable_limit  <= cfg_wdata;
        REG_MIN_SAMPLES:   cfg.min_samples   <= cfg_wdata[SAMPLE_W-1:0];
        REG_RUN_THRESHOLD: cfg.run_threshold <= cfg_wdata;
        REG_TEETH_PER_REV: cfg.teeth_per_rev <= cfg_wdata[TOOTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_period <= s_tdata;
    end
  end

  mtcd_step u_step (
    .cfg       (cfg),
    .st        (st),
    .period    (in_period),
    .old_entry (window[st.window_pointer]),
    .st_next   (st_next),
    .win       (win),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_INIT;
      st.sample_count   <= '0;
      st.tooth_pos      <= TOOTH_FIRST;
      st.window_pointer <= '0;
      st.period_sum     <= '0;
      st.fault          <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
    end else if (fire && win.clear) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
    end else if (fire && win.push) begin
      window[st.window_pointer] <= in_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'd0, out_res.fault, out_res.average_period, out_res.tooth_number,
                    out_res.tooth_tick, out_res.sync_mark, out_res.engine_status};

  a_mark_tick_excl : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.sync_mark && out_res.tooth_tick))
    else $error("sync mark and tooth tick raised together");

  a_number_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.sync_mark && !out_res.tooth_tick) |-> (out_res.tooth_number == '0))
    else $error("tooth number set outside sync");

  a_fault_sticky : assert property (@(posedge clk) disable iff (rst)
    st.fault |=> st.fault)
    else $error("fault latch cleared without reset");

  a_stall_only : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output can drain");

  a_tick_synced : assert property (@(posedge clk) disable iff (rst)
    (fire && res.tooth_tick) |-> (st.phase == PH_SYNC))
    else $error("tooth tick outside synced phase");

endmodule

### sim/tb_missing_tooth_crank_decoder.sv
// Self-checking testbench for missing_tooth_crank_decoder: streams tooth periods in, checks
// every status word against a cycle-free predictor held in a small scoreboard class.
// Depends on mtcd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_missing_tooth_crank_decoder;
  import mtcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_AFTER = 180;
  localparam int HOLD_OFF_LEN   = 300;

  localparam logic [PERIOD_W-1:0] OPENING_RUN [19] = '{
    16'd0, 16'd65535, 16'd165,
    16'd166, 16'd19999, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
    16'd1000, 16'd1000, 16'd1000, 16'd1000,
    16'd2000, 16'd2251,
    16'd1200, 16'd800, 16'd30,
    16'd20000
  };

  class crank_scoreboard;
    cfg_t                regs;
    phase_t              stage;
    logic [SAMPLE_W-1:0] stable_seen;
    logic [TOOTH_W-1:0]  teeth_seen;
    logic [PERIOD_W-1:0] ring [WINDOW_DEPTH];
    logic [WIN_AW-1:0]   ring_slot;
    logic [SUM_W-1:0]    ring_total;
    logic                fault_seen;
    result_t             decodes_due [$];
    int                  failures;
    int                  reported;

    function new();
      regs.min_period    = 16'd166;
      regs.max_period    = 16'd65535;
      regs.stable_limit  = 16'd20000;
      regs.min_samples   = 4'd10;
      regs.run_threshold = 16'd2000;
      regs.teeth_per_rev = 6'd58;
      stage       = PH_INIT;
      stable_seen = '0;
      teeth_seen  = TOOTH_FIRST;
      fault_seen  = 1'b0;
      failures    = 0;
      reported    = 0;
      clear_ring();
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_MIN_PERIOD:    regs.min_period    = val;
        REG_MAX_PERIOD:    regs.max_period    = val;
        REG_STABLE_LIMIT:  regs.stable_limit  = val;
        REG_MIN_SAMPLES:   regs.min_samples   = val[SAMPLE_W-1:0];
        REG_RUN_THRESHOLD: regs.run_threshold = val;
        REG_TEETH_PER_REV: regs.teeth_per_rev = val[TOOTH_W-1:0];
        default: ;
      endcase
    endfunction

    function void clear_ring();
      foreach (ring[i]) ring[i] = '0;
      ring_total = '0;
      ring_slot  = '0;
    endfunction

    function void push_ring(logic [PERIOD_W-1:0] p);
      ring_total      = ring_total + p - ring[ring_slot];
      ring[ring_slot] = p;
      ring_slot       = (ring_slot == PTR_LAST) ? '0 : ring_slot + 1'b1;
    endfunction

    function logic [PERIOD_W-1:0] mean_period();
      return PERIOD_W'(ring_total / WINDOW_DEPTH);
    endfunction

    function int pending();
      return decodes_due.size();
    endfunction

    // Works out the status word that one accepted tooth period produces.
    function void note_period(logic [PERIOD_W-1:0] p);
      result_t             r;
      logic [PERIOD_W-1:0] avg;
      logic                is_gap;
      r = '0;
      if (p > regs.max_period || p < regs.min_period) begin
        if (stage == PH_SYNC) fault_seen = 1'b1;
        stage = PH_INIT;
      end
      avg    = mean_period();
      is_gap = ({1'b0, p} > {avg, 1'b0});
      case (stage)
        PH_INIT: begin
          stable_seen = '0;
          teeth_seen  = TOOTH_FIRST;
          clear_ring();
          stage = PH_GATHER;
        end
        PH_GATHER: begin
          if (p < regs.stable_limit) begin
            push_ring(p);
            if (stable_seen >= regs.min_samples) begin
              stable_seen = '0;
              stage = PH_HUNT;
            end
          end else begin
            stage = PH_INIT;
          end
        end
        PH_HUNT: begin
          r.engine_status = STATUS_CRANK;
          if (is_gap) begin
            stable_seen    = '0;
            teeth_seen     = TOOTH_FIRST;
            r.sync_mark    = 1'b1;
            r.tooth_number = teeth_seen;
            stage = PH_SYNC;
          end else begin
            push_ring(p);
          end
        end
        default: begin
          r.engine_status = (avg > regs.run_threshold) ? STATUS_CRANK : STATUS_RUN;
          if (teeth_seen >= regs.teeth_per_rev) begin
            teeth_seen = TOOTH_FIRST;
            if (!is_gap) begin
              fault_seen = 1'b1;
              stage = PH_INIT;
            end
          end else begin
            teeth_seen = teeth_seen + 1'b1;
            push_ring(p);
          end
          r.tooth_tick   = 1'b1;
          r.tooth_number = teeth_seen;
        end
      endcase
      if (stable_seen < SAMPLE_MAX) stable_seen = stable_seen + 1'b1;
      r.average_period = mean_period();
      r.fault          = fault_seen;
      decodes_due.push_back(r);
    endfunction

    function void check_result(logic [OUT_DW-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[$bits(result_t)-1:0]);
      if (decodes_due.size() == 0) begin
        failures++;
        if (reported < 10) $display("unexpected status word %h with no request outstanding", word);
        reported++;
      end else begin
        want = decodes_due.pop_front();
        if (word[OUT_DW-1:$bits(result_t)] != '0 ||
            got.engine_status != want.engine_status || got.sync_mark != want.sync_mark ||
            got.tooth_tick != want.tooth_tick || got.tooth_number != want.tooth_number ||
            got.average_period != want.average_period || got.fault != want.fault) begin
          failures++;
          if (reported < 10)
            $display("mismatch: expected status %0d mark %0b tick %0b tooth %0d avg %0d fault %0b,",
                     want.engine_status, want.sync_mark, want.tooth_tick, want.tooth_number,
                     want.average_period, want.fault,
                     " got status %0d mark %0b tick %0b tooth %0d avg %0d fault %0b pad %0h",
                     got.engine_status, got.sync_mark, got.tooth_tick, got.tooth_number,
                     got.average_period, got.fault, word[OUT_DW-1:$bits(result_t)]);
          reported++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [PERIOD_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_DW-1:0]   m_tdata;

  crank_scoreboard sb = new();
  cfg_t            wheel_cfg;
  int              period_count;
  int              quiet;
  int              calm_left [2];

  missing_tooth_crank_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin : bus_monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
      if (s_tvalid && s_tready === 1'b1) begin
        sb.note_period(s_tdata);
        moved = 1'b1;
      end
      if (m_tvalid === 1'b1 && m_tready) begin
        sb.check_result(m_tdata);
        moved = 1'b1;
      end
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, and occasional stretches of back-to-back traffic.
  function automatic int idle_len(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PERIOD_W-1:0] noise_period();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2 && wheel_cfg.min_period != 0)
      return PERIOD_W'($urandom_range(0, int'(wheel_cfg.min_period) - 1));
    if (r == 3) return wheel_cfg.min_period;
    return PERIOD_W'($urandom);
  endfunction

  // One interval of a spinning wheel; sometimes the gap goes missing or turns up early.
  function automatic logic [PERIOD_W-1:0] wheel_period(input int base, input bit at_gap);
    int r;
    bit gap_now;
    r = $urandom_range(0, 99);
    gap_now = at_gap;
    if (r < 2) return noise_period();
    if (at_gap && r < 7) gap_now = 1'b0;
    else if (!at_gap && r == 7) gap_now = 1'b1;
    if (gap_now) return PERIOD_W'(3 * base);
    return PERIOD_W'(base - base / 16 + $urandom_range(0, base / 8));
  endfunction

  task automatic send_period(input logic [PERIOD_W-1:0] p);
    int gap;
    gap = idle_len(0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    period_count++;
  endtask

  task automatic run_wheel();
    int mn, mx, st, lo, hi, base, tpr, lead, revs;
    mn = int'(wheel_cfg.min_period);
    mx = int'(wheel_cfg.max_period);
    st = int'(wheel_cfg.stable_limit);
    lo = mn + mn / 8 + 16;
    hi = ((st - 1) * 15) / 16;
    if (hi > mx / 3) hi = mx / 3;
    if (hi < lo) begin
      repeat ($urandom_range(10, 30)) send_period(noise_period());
    end else begin
      if ($urandom_range(0, 1) == 0 && hi > lo + 2500) base = $urandom_range(lo, lo + 2500);
      else base = $urandom_range(lo, hi);
      tpr  = (wheel_cfg.teeth_per_rev < 2) ? 1 : int'(wheel_cfg.teeth_per_rev);
      lead = int'(wheel_cfg.min_samples) + $urandom_range(1, 6);
      revs = $urandom_range(1, 3);
      repeat (lead) send_period(wheel_period(base, 1'b0));
      repeat (revs) begin
        for (int k = 1; k <= tpr; k++) send_period(wheel_period(base, k == tpr));
      end
    end
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DW'(val);
    @(posedge clk);
  endtask

  task automatic run_phase(input int mn, input int mx, input int st, input int ms,
                           input int rt, input int tpr, input int quota);
    int target;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(REG_MIN_PERIOD, mn);
    put_reg(REG_MAX_PERIOD, mx);
    put_reg(REG_STABLE_LIMIT, st);
    put_reg(REG_MIN_SAMPLES, ms);
    put_reg(REG_RUN_THRESHOLD, rt);
    put_reg(REG_TEETH_PER_REV, tpr);
    cfg_we <= 1'b0;
    wheel_cfg.min_period    = PERIOD_W'(mn);
    wheel_cfg.max_period    = PERIOD_W'(mx);
    wheel_cfg.stable_limit  = PERIOD_W'(st);
    wheel_cfg.min_samples   = SAMPLE_W'(ms);
    wheel_cfg.run_threshold = PERIOD_W'(rt);
    wheel_cfg.teeth_per_rev = TOOTH_W'(tpr);
    target = period_count + quota;
    while (period_count < target) run_wheel();
  endtask

  initial begin : result_sink
    int stall;
    int seen;
    bit held;
    stall = 0;
    seen  = 0;
    held  = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        seen++;
        stall = idle_len(1);
      end
      if (!held && seen >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_wdata    <= '0;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    period_count = 0;
    quiet        = 0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    wheel_cfg    = sb.regs;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: glitches below the minimum period, a gather restart, the exact gap
    // boundary, sync, a glitch while synced and a restart in gather.
    foreach (OPENING_RUN[i]) send_period(OPENING_RUN[i]);

    run_phase(0, 65535, 65535, 1, 0, 2, 100);
    run_phase(100, 60000, 20000, 15, 65535, 63, 120);
    run_phase(65535, 65535, 0, 4, 2000, 30, 30);
    run_phase(166, 40000, 12000, 8, 1500, 12, 100);
    run_phase(0, 0, 65535, 3, 0, 20, 20);
    run_phase(200, 65535, 30000, 9, 3000, 1, 60);
    run_phase(166, 65535, 20000, 10, 2000, 58, 60);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
